### rtl/pskdm_pkg.sv
// Shared types and the arctangent table for the PSK hard-decision demapper.
`default_nettype none

package pskdm_pkg;

  // Binary angle width: 2^32 is one full turn.
  localparam int unsigned AngleW = 32;
  // Number of entries held in the arctangent table.
  localparam int unsigned AtanDepth = 24;
  localparam int unsigned AtanIdxW = 5;

  // Result of one phase pass, handed from the CORDIC unit to the packer.
  typedef struct packed {
    logic              done;   // one-cycle pulse when the phase is final
    logic              zero;   // sample was the zero vector
    logic [AngleW-1:0] phase;  // binary angle, held until the next start
  } cordic_res_t;

  // atan(2^-i) scaled to binary angle units, rounded to nearest.
  function automatic logic [AngleW-1:0] atan_lut(input logic [AtanIdxW-1:0] idx);
    logic [AngleW-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### rtl/pskdm_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle on a shared adder set.
`default_nettype none

module pskdm_cordic #(
  parameter int unsigned SAMPLE_WIDTH     = 16,
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire signed [SAMPLE_WIDTH-1:0] x_i,
  input  wire signed [SAMPLE_WIDTH-1:0] y_i,
  output pskdm_pkg::cordic_res_t        res_o
);

  // Headroom for the pre-rotation negate and the CORDIC gain.
  localparam int unsigned XW   = SAMPLE_WIDTH + 3;
  localparam int unsigned IT_W = $clog2(ANGLE_ITERATIONS);
  localparam int unsigned AW   = pskdm_pkg::AngleW;

  typedef enum logic {
    C_IDLE,
    C_ROT
  } cstate_e;

  cstate_e             state_q, state_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [AW-1:0]        z_q, z_d;
  logic [IT_W-1:0]      it_q, it_d;
  logic                 zero_q, zero_d;
  logic                 done_q, done_d;

  logic signed [XW-1:0] x_ld, y_ld, dx, dy;
  logic [AW-1:0]        atan_val;
  logic                 last_it;

  // Sign-extend the sample; the left half-plane is folded onto the right at load.
  always_comb begin
    x_ld = {{(XW-SAMPLE_WIDTH){x_i[SAMPLE_WIDTH-1]}}, x_i};
    y_ld = {{(XW-SAMPLE_WIDTH){y_i[SAMPLE_WIDTH-1]}}, y_i};
  end

  // Shared shift and table lookup for the current micro-rotation.
  assign dx       = y_q >>> it_q;
  assign dy       = x_q >>> it_q;
  assign atan_val = pskdm_pkg::atan_lut(pskdm_pkg::AtanIdxW'(it_q));
  assign last_it  = (it_q == IT_W'(ANGLE_ITERATIONS - 1));

  // Sequence load, rotations and the done pulse.
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    it_d    = it_q;
    zero_d  = zero_q;
    done_d  = 1'b0;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          zero_d  = (x_i == '0) && (y_i == '0);
          it_d    = '0;
          state_d = C_ROT;
          if (x_i[SAMPLE_WIDTH-1]) begin
            x_d = -x_ld;
            y_d = -y_ld;
            z_d = {1'b1, {(AW-1){1'b0}}};
          end else begin
            x_d = x_ld;
            y_d = y_ld;
            z_d = '0;
          end
        end
      end
      C_ROT: begin
        if (!y_q[XW-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_val;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_val;
        end
        it_d = it_q + 1'b1;
        if (last_it) begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Hold control state and the datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      it_q    <= '0;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      done_q  <= done_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign res_o.done  = done_q;
  assign res_o.zero  = zero_q;
  assign res_o.phase = z_q;

  // A start is only taken while idle, and done follows the last rotation.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_ROT && last_it) |=> (done_q && state_q == C_IDLE))
    else $error("done did not follow the last rotation");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == C_IDLE))
    else $error("done raised while rotating");

  a_it_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_IDLE && start_i) |=> (it_q == '0))
    else $error("iteration counter not cleared at start");

endmodule

`default_nettype wire

### rtl/psk_hard_demapper_packer.sv
// Top level: M-PSK hard-decision demapper that packs symbol indices into bytes.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: i_sample, q_sample
//   m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: packed_byte
//   cfg       in   cfg_we_i                         cfg_wdata_i: bits_per_symbol_mode
//
// After a transfer the sample is loaded into the CORDIC unit, which makes
// one micro-rotation per cycle; its done pulse starts the pack step, then ready returns.
// s_axis_tready_o is low from the transfer until the pack step ends: one sample at a time.
// Reset clears the packer (bit position 0, empty byte) and sets the mode to QPSK.
// With a finished byte, a full output register and m_axis_tready_i low hold the pack step.
`default_nettype none

module psk_hard_demapper_packer #(
  parameter int unsigned SAMPLE_WIDTH     = 16,
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // Bits from the lowest: i_sample [SAMPLE_WIDTH-1:0], q_sample next, zero fill.
  input  wire [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Bits from the lowest: packed_byte [7:0].
  output logic [7:0]             m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  input  wire                    cfg_we_i,
  input  wire [1:0]              cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_PACK
  } state_e;

  state_e                  state_q;
  logic [1:0]              mode_q;
  logic [2:0]              bit_pos_q;
  logic [7:0]              partial_q;
  logic [7:0]              out_data_q;
  logic                    out_valid_q;

  pskdm_pkg::cordic_res_t  cres;
  logic                    in_xfer, out_xfer;
  logic [3:0]              bps;
  logic [31:0]             rounded;
  logic [7:0]              sym;
  logic [7:0]              merged;
  logic [3:0]              pos_sum;
  logic                    emit, slot_free;
  logic                    load_out;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Phase of the sample, one micro-rotation per cycle.
  pskdm_cordic #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .x_i     (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .y_i     (s_axis_tdata_i[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .res_o   (cres)
  );

  // Decide the nearest point: add half a sector, keep the top b bits.
  always_comb begin
    bps     = 4'd1 << mode_q;
    rounded = cres.phase + (32'h1 << (5'd31 - 5'(bps)));
    sym     = cres.zero ? 8'h00 : 8'(rounded >> (6'd32 - 6'(bps)));
    merged  = partial_q | (sym << bit_pos_q);
    pos_sum = {1'b0, bit_pos_q} + bps;
    emit    = (pos_sum >= 4'd8);
  end

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign load_out        = (state_q == S_PACK) && emit && slot_free;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Hold state, the packer and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 2'd1;
      bit_pos_q   <= '0;
      partial_q   <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      // Load a finished byte, or clear the register once it is taken.
      if (load_out) begin
        out_data_q  <= merged;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (cres.done) begin
            state_q <= S_PACK;
          end
        end
        S_PACK: begin
          if (!emit) begin
            partial_q <= merged;
            bit_pos_q <= pos_sum[2:0];
            state_q   <= S_IDLE;
          end else if (slot_free) begin
            partial_q   <= '0;
            bit_pos_q   <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Ready drops for the whole item after a transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("ready stayed high after an input transfer");

  // Phase results arrive only while an item is waiting on them.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cres.done |-> (state_q == S_WAIT))
    else $error("phase result outside the wait state");

  // An emitted byte restarts the packer.
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PACK && emit && slot_free) |=> (bit_pos_q == '0 && out_valid_q))
    else $error("packer did not restart after emitting a byte");

endmodule

`default_nettype wire

### dv/psk_hard_demapper_packer_test.sv
// Self-checking testbench for the PSK hard-decision demapper and byte packer.
`default_nettype none

module psk_hard_demapper_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned CordicIter = 16;
  localparam int unsigned DataW      = ((2*SampleW+7)/8)*8;
  // Cycles the block may still be busy after its last transfer.
  localparam int unsigned SettleCycles = CordicIter + 12;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomItems  = 850;

  typedef enum logic [1:0] {
    MODE_BPSK   = 2'd0,
    MODE_QPSK   = 2'd1,
    MODE_16PSK  = 2'd2,
    MODE_256PSK = 2'd3
  } psk_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic [DataW-1:0] s_data = '0;
  logic             s_valid = 1'b0;
  wire              s_axis_tready_o;
  wire  [7:0]       m_axis_tdata_o;
  wire              m_axis_tvalid_o;
  logic             m_ready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_wdata = '0;

  // Predictor state: current mode, packer position and partial byte.
  psk_mode_e   mode_now = MODE_QPSK;
  int unsigned pack_pos = 0;
  logic [7:0]  pack_byte = '0;
  logic [7:0]  expected_bytes [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  psk_hard_demapper_packer #(
    .SAMPLE_WIDTH     (SampleW),
    .ANGLE_ITERATIONS (CordicIter)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // Micro-rotation angles, atan(2^-n) in binary angle units.
  function automatic logic [31:0] rotation_angle(input int unsigned n);
    case (n)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      20:      return 32'h0000028C;
      21:      return 32'h00000146;
      22:      return 32'h000000A3;
      23:      return 32'h00000051;
      default: return 32'h0;
    endcase
  endfunction

  // Vectoring pass: rotate the sample onto the positive x axis, accumulate its angle.
  function automatic logic [31:0] sample_phase(input logic signed [15:0] i_s,
                                               input logic signed [15:0] q_s);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [31:0]        z;
    x = i_s;
    y = q_s;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int unsigned n = 0; n < CordicIter && n < 24; n++) begin
      dx = y >>> n;
      dy = x >>> n;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + rotation_angle(n);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - rotation_angle(n);
      end
    end
    return z;
  endfunction

  // Nearest constellation index; boundaries round up, the top one wraps to 0.
  function automatic logic [7:0] symbol_index(input logic signed [15:0] i_s,
                                              input logic signed [15:0] q_s,
                                              input psk_mode_e m);
    int unsigned b;
    logic [31:0] z;
    b = 1 << m;
    if (i_s == 0 && q_s == 0) return 8'd0;
    z = sample_phase(i_s, q_s) + (32'd1 << (31 - b));
    return 8'(z >> (32 - b));
  endfunction

  // Pack one symbol; queue the byte once it is full.
  task automatic pack_symbol(input logic [7:0] k);
    int unsigned b;
    b = 1 << mode_now;
    pack_byte = pack_byte | 8'({8'd0, k} << pack_pos);
    if (pack_pos + b >= 8) begin
      expected_bytes.push_back(pack_byte);
      pack_byte = '0;
      pack_pos = 0;
    end else begin
      pack_pos = pack_pos + b;
    end
  endtask

  task automatic note_failure(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_v, act_v);
  endtask

  // Offer one sample and hold it until the transfer.
  task automatic send_sample(input logic signed [15:0] i_s, input logic signed [15:0] q_s);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_data  <= {q_s, i_s};
    s_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pack_symbol(symbol_index(i_s, q_s, mode_now));
  endtask

  // Stop sending, wait for every expected byte, then let the pipeline empty.
  task automatic drain_outputs();
    s_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input psk_mode_e m);
    drain_outputs();
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    mode_now = m;
  endtask

  // Mix of tiny, on-axis, diagonal and full-range samples.
  task automatic send_random_sample();
    logic signed [15:0] i_s;
    logic signed [15:0] q_s;
    logic signed [15:0] a;
    a   = 16'($urandom());
    i_s = 16'($urandom());
    q_s = 16'($urandom());
    case ($urandom_range(0, 9))
      0, 1: begin
        i_s = 16'($signed($urandom_range(0, 8)) - 4);
        q_s = 16'($signed($urandom_range(0, 8)) - 4);
      end
      2: begin
        if ($urandom_range(0, 1)) i_s = '0;
        else q_s = '0;
      end
      3: begin
        i_s = a;
        q_s = $urandom_range(0, 1) ? a : -a;
      end
      default: ;
    endcase
    send_sample(i_s, q_s);
  endtask

  // Reset mode is QPSK: extremes, axes, diagonals and the zero vector.
  task automatic test_reset_qpsk();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(16'sd0, 16'sd32767);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd1000, 16'sd1000);
    send_sample(-16'sd32768, 16'sd32767);
  endtask

  // Walk through BPSK, 16-PSK and 256-PSK, both extreme modes included.
  task automatic test_mode_write();
    set_mode(MODE_BPSK);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd1);
    send_sample(-16'sd32768, -16'sd1);
    send_sample(16'sd5, 16'sd0);
    send_sample(-16'sd5, 16'sd0);
    set_mode(MODE_16PSK);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd300, 16'sd124);
    set_mode(MODE_256PSK);
    send_sample(16'sd32767, -16'sd2);
  endtask

  // Change the mode while a byte is partly filled.
  task automatic test_mode_change_mid_byte();
    set_mode(MODE_QPSK);
    send_sample(-16'sd20000, 16'sd3);
    set_mode(MODE_256PSK);
    send_sample(-16'sd7, -16'sd32768);
    set_mode(MODE_16PSK);
    send_sample(16'sd4, 16'sd9);
    set_mode(MODE_QPSK);
    send_sample(16'sd12345, -16'sd23456);
    send_sample(-16'sd2, 16'sd2);
  endtask

  // Random phases, each with its own idling pattern and usually a new mode.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_no;
    psk_mode_e   m;
    sent = 0;
    phase_no = 0;
    while (sent < RandomItems) begin
      case (phase_no)
        0:       m = MODE_BPSK;
        1:       m = MODE_256PSK;
        default: m = psk_mode_e'($urandom_range(0, 3));
      endcase
      if (phase_no == 0 || $urandom_range(0, 3) != 0) set_mode(m);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      for (int unsigned n = 0; n < phase_len && sent < RandomItems; n++) begin
        send_random_sample();
        sent++;
        // Occasionally hold off until the output side catches up.
        if ($urandom_range(0, 49) == 0) drain_outputs();
      end
      phase_no++;
    end
    no_idle = 1'b0;
  endtask

  // Output side: random stalls, compare each transfer with the oldest expected byte.
  initial begin
    int unsigned gap;
    logic [7:0]  exp_v;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      if (expected_bytes.size() == 0) begin
        note_failure("unexpected byte", 8'h00, m_axis_tdata_o);
      end else begin
        exp_v = expected_bytes.pop_front();
        if (m_axis_tdata_o !== exp_v) note_failure("packed_byte", exp_v, m_axis_tdata_o);
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_qpsk();
    test_mode_write();
    test_mode_change_mid_byte();
    test_random_traffic();
    drain_outputs();
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
